[sv/dqss_pkg.sv]
package dqss_pkg;

  localparam int WINDOW_LEN = 128;
  localparam int UPDATE_PERIOD = 64;

  localparam int ERR_W = 16;
  localparam int SUM_W = ERR_W + $clog2(WINDOW_LEN);
  localparam int MEAN_SHIFT = $clog2(WINDOW_LEN + 1) - 1;
  localparam int MEAN_W = SUM_W - MEAN_SHIFT;
  localparam int PERIOD_W = (UPDATE_PERIOD > 1) ? $clog2(UPDATE_PERIOD) : 1;
  localparam logic [PERIOD_W-1:0] PERIOD_LAST = PERIOD_W'(UPDATE_PERIOD - 1);

  localparam logic [13:0] COS45_Q14 = 14'd11585;

  localparam int CFG_W = 32;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_AMP_GATE_SQ = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GATED_ERROR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_THRESHOLD = 2'd2;

  localparam logic [31:0] AMP_GATE_SQ_RESET = 32'd6039798;
  localparam logic [15:0] GATED_ERROR_RESET = 16'd5734;
  localparam logic [15:0] SYNC_THRESHOLD_RESET = 16'd5734;

  typedef struct packed {
    logic signed [15:0] in_re;
    logic signed [15:0] in_im;
  } in_t;

  typedef struct packed {
    logic [1:0] dibit;
    logic in_sync;
    logic [15:0] mean_error;
  } out_t;

  typedef struct packed {
    logic valid;
    logic [1:0] dibit;
    logic [ERR_W-1:0] err;
  } err_item_t;

  typedef struct packed {
    logic valid;
    logic [1:0] dibit;
    logic latch;
  } win_item_t;

  function automatic logic [1:0] gray_map(input logic [1:0] diff);
    logic [1:0] g;
    unique case (diff)
      2'd0: g = 2'd0;
      2'd1: g = 2'd1;
      2'd2: g = 2'd3;
      2'd3: g = 2'd2;
      default: g = 2'd0;
    endcase
    return g;
  endfunction

endpackage

[sv/dqss_cell.sv]
module dqss_cell
  import dqss_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic shift,
  input  logic [ERR_W-1:0] d,
  output logic [ERR_W-1:0] q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

[sv/dqss_err.sv]
module dqss_err
  import dqss_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  in_t in_data,
  input  logic [31:0] amp_gate_sq,
  input  logic [15:0] gated_error,
  output err_item_t item
);

  logic [1:0] prev_symbol;
  logic sign_im;
  logic sign_re;
  logic [1:0] sym;
  logic [1:0] diff;
  logic signed [16:0] re_x;
  logic signed [16:0] im_x;
  logic signed [16:0] x;
  logic signed [16:0] y;
  logic signed [17:0] d;
  logic signed [17:0] d_neg;
  logic [16:0] ad_next;
  logic [15:0] ure_next;
  logic [15:0] uim_next;
  logic [15:0] re_neg;
  logic [15:0] im_neg;

  logic a_valid;
  logic [1:0] a_dibit;
  logic [16:0] a_ad;
  logic [15:0] a_ure;
  logic [15:0] a_uim;

  logic b_valid;
  logic [1:0] b_dibit;
  logic [30:0] b_perr;
  logic [31:0] b_sq_re;
  logic [31:0] b_sq_im;

  logic [31:0] mag2;
  logic [16:0] err_raw;
  logic [ERR_W-1:0] err_next;

  always_comb begin
    sign_im = in_data.in_im[15];
    sign_re = in_data.in_re[15];
    sym = {sign_im, sign_im ^ sign_re};
    diff = sym - prev_symbol;
    re_x = 17'(in_data.in_re);
    im_x = 17'(in_data.in_im);
    x = sign_im ? -re_x : re_x;
    y = sign_re ? -im_x : im_x;
    d = 18'(x) - 18'(y);
    d_neg = -d;
    ad_next = d[17] ? d_neg[16:0] : d[16:0];
    re_neg = 16'(-in_data.in_re);
    im_neg = 16'(-in_data.in_im);
    ure_next = sign_re ? re_neg : 16'(in_data.in_re);
    uim_next = sign_im ? im_neg : 16'(in_data.in_im);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_symbol <= '0;
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      item.valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
      b_valid <= a_valid;
      item.valid <= b_valid;
      if (in_valid) begin
        prev_symbol <= sym;
      end
    end
  end

  always_comb begin
    mag2 = b_sq_re + b_sq_im;
    err_raw = b_perr[30:14];
    err_next = err_raw[16] ? {ERR_W{1'b1}} : err_raw[15:0];
    if (mag2 < amp_gate_sq) begin
      err_next = gated_error;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_dibit <= gray_map(diff);
      a_ad <= ad_next;
      a_ure <= ure_next;
      a_uim <= uim_next;
      b_dibit <= a_dibit;
      b_perr <= 31'({14'd0, a_ad} * {17'd0, COS45_Q14});
      b_sq_re <= {16'd0, a_ure} * {16'd0, a_ure};
      b_sq_im <= {16'd0, a_uim} * {16'd0, a_uim};
      item.dibit <= b_dibit;
      item.err <= err_next;
    end
  end

endmodule

[sv/dqss_window.sv]
module dqss_window
  import dqss_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  err_item_t item,
  output win_item_t win,
  output logic [SUM_W-1:0] error_sum
);

  logic shift;
  logic [ERR_W-1:0] tap [WINDOW_LEN];
  logic [PERIOD_W-1:0] period_count;

  assign shift = en && item.valid;

  genvar i;
  generate
    for (i = 0; i < WINDOW_LEN; i++) begin : g_cell
      if (i == 0) begin : g_head
        dqss_cell u_cell (
          .clk(clk),
          .rst(rst),
          .shift(shift),
          .d(item.err),
          .q(tap[i])
        );
      end else begin : g_body
        dqss_cell u_cell (
          .clk(clk),
          .rst(rst),
          .shift(shift),
          .d(tap[i-1]),
          .q(tap[i])
        );
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum <= '0;
      period_count <= '0;
      win.valid <= 1'b0;
      win.latch <= 1'b0;
    end else if (en) begin
      win.valid <= item.valid;
      win.latch <= 1'b0;
      if (item.valid) begin
        error_sum <= error_sum - SUM_W'(tap[WINDOW_LEN-1]) + SUM_W'(item.err);
        if (period_count == PERIOD_LAST) begin
          period_count <= '0;
          win.latch <= 1'b1;
        end else begin
          period_count <= period_count + PERIOD_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      win.dibit <= item.dibit;
    end
  end

endmodule

[sv/dqpsk_symbol_slicer_sync_core.sv]
// An accepted symbol passes error registers a, b and item, then the window and output registers.
// Throughput: one symbol per cycle; the whole pipeline holds only while a result waits unclaimed.
// The error window is a row of delay cells that shifts once per symbol, with a running sum.
// Reset is synchronous and active high; it clears all cells, the sum, the counters and the flags,
// and loads the configuration registers with their default values.
module dqpsk_symbol_slicer_sync_core
  import dqss_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data,
  input  logic cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  logic en;
  logic [31:0] amp_gate_sq;
  logic [15:0] gated_error;
  logic [15:0] sync_threshold;
  err_item_t err_item;
  win_item_t win;
  logic [SUM_W-1:0] error_sum;
  logic [MEAN_W-1:0] mean_full;
  logic [15:0] mean_next;
  logic sync_next;
  logic sync_flag;
  logic [15:0] latched_mean;

  assign en = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      amp_gate_sq <= AMP_GATE_SQ_RESET;
      gated_error <= GATED_ERROR_RESET;
      sync_threshold <= SYNC_THRESHOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_AMP_GATE_SQ: amp_gate_sq <= cfg_data[31:0];
        CFG_GATED_ERROR: gated_error <= cfg_data[15:0];
        CFG_SYNC_THRESHOLD: sync_threshold <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  dqss_err u_err (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(in_valid),
    .in_data(in_data),
    .amp_gate_sq(amp_gate_sq),
    .gated_error(gated_error),
    .item(err_item)
  );

  dqss_window u_window (
    .clk(clk),
    .rst(rst),
    .en(en),
    .item(err_item),
    .win(win),
    .error_sum(error_sum)
  );

  always_comb begin
    mean_full = error_sum[SUM_W-1:MEAN_SHIFT];
    mean_next = (mean_full > MEAN_W'(65535)) ? 16'hFFFF : mean_full[15:0];
    sync_next = mean_next < sync_threshold;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_flag <= 1'b0;
      latched_mean <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= win.valid;
      if (win.valid && win.latch) begin
        sync_flag <= sync_next;
        latched_mean <= mean_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.dibit <= win.dibit;
      if (win.latch) begin
        out_data.in_sync <= sync_next;
        out_data.mean_error <= mean_next;
      end else begin
        out_data.in_sync <= sync_flag;
        out_data.mean_error <= latched_mean;
      end
    end
  end

endmodule

[dv/dqpsk_demap_checker.sv]
module dqpsk_demap_checker
  import dqss_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_ready,
  input  in_t in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  out_t out_data,
  input  logic cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output int failures
);

  localparam int WIN_SHIFT = $clog2(WINDOW_LEN + 1) - 1;
  localparam longint COS45 = 11585;

  logic [31:0] gate_sq;
  logic [15:0] weak_error;
  logic [15:0] sync_limit;

  logic [1:0] last_symbol;
  logic [15:0] error_window [WINDOW_LEN];
  int window_pos;
  longint window_sum;
  int period_cnt;
  logic sync_state;
  logic [15:0] held_mean;

  out_t pending_results[$];
  int mismatches = 0;

  initial failures = 0;

  function automatic out_t demap_symbol(in_t s);
    longint re, im, d, ad, err, mag2, mean;
    logic neg_re, neg_im;
    logic [1:0] sym, diff;
    out_t r;
    re = s.in_re;
    im = s.in_im;
    neg_im = im < 0;
    neg_re = re < 0;
    d = (neg_im ? -re : re) - (neg_re ? -im : im);
    ad = (d < 0) ? -d : d;
    err = (ad * COS45) >> 14;
    if (err > 65535) begin
      err = 65535;
    end
    mag2 = re * re + im * im;
    if (mag2 < longint'({32'b0, gate_sq})) begin
      err = weak_error;
    end
    window_sum = window_sum - error_window[window_pos] + err;
    error_window[window_pos] = err[15:0];
    window_pos = (window_pos + 1) % WINDOW_LEN;
    period_cnt++;
    if (period_cnt >= UPDATE_PERIOD) begin
      mean = window_sum >> WIN_SHIFT;
      if (mean > 65535) begin
        mean = 65535;
      end
      held_mean = mean[15:0];
      sync_state = (mean >= longint'(sync_limit)) ? 1'b0 : 1'b1;
      period_cnt = 0;
    end
    sym = {neg_im, neg_im ^ neg_re};
    diff = sym - last_symbol;
    last_symbol = sym;
    r.dibit = {diff[1], diff[1] ^ diff[0]};
    r.in_sync = sync_state;
    r.mean_error = held_mean;
    return r;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      gate_sq = AMP_GATE_SQ_RESET;
      weak_error = GATED_ERROR_RESET;
      sync_limit = SYNC_THRESHOLD_RESET;
      last_symbol = 2'd0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        error_window[i] = 16'd0;
      end
      window_pos = 0;
      window_sum = 0;
      period_cnt = 0;
      sync_state = 1'b0;
      held_mean = 16'd0;
      pending_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_AMP_GATE_SQ: gate_sq = cfg_data;
          CFG_GATED_ERROR: weak_error = cfg_data[15:0];
          CFG_SYNC_THRESHOLD: sync_limit = cfg_data[15:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Unexpected transaction on the output: dibit %0d sync %0d mean %0d",
                     out_data.dibit, out_data.in_sync, out_data.mean_error);
          end
        end else begin
          want = pending_results.pop_front();
          if (out_data.dibit !== want.dibit || out_data.in_sync !== want.in_sync ||
              out_data.mean_error !== want.mean_error) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Mismatch: dibit %0d/%0d sync %0d/%0d mean %0d/%0d (expected/actual)",
                       want.dibit, out_data.dibit, want.in_sync, out_data.in_sync,
                       want.mean_error, out_data.mean_error);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        pending_results.push_back(demap_symbol(in_data));
      end
    end
    failures = mismatches + pending_results.size();
  end

endmodule

[dv/dqpsk_symbol_slicer_sync_core_test.sv]
module dqpsk_symbol_slicer_sync_core_test;
  import dqss_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_AMP_GATE_SQ;
  logic [CFG_W-1:0] cfg_data = '0;

  int failures;
  int sent_count = 0;
  int done_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_left = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  dqpsk_symbol_slicer_sync_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  dqpsk_demap_checker demap_check (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .failures(failures)
  );

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        sent_count <= sent_count + 1;
      end
      if (out_valid && out_ready) begin
        done_count <= done_count + 1;
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(99, 0) < recv_idle_pct) begin
      stall_left <= $urandom_range(6, 0);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_symbol(input logic signed [15:0] re, input logic signed [15:0] im);
    int gap;
    if ($urandom_range(99, 0) < send_idle_pct) begin
      gap = $urandom_range(7, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{in_re: re, in_im: im};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_random(input int count, input int noise);
    int kind;
    int radius;
    int re_v;
    int im_v;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(9, 0);
      if (kind < 7) begin
        radius = $urandom_range(14000, 9000);
        re_v = radius + int'($urandom_range(2 * noise, 0)) - noise;
        im_v = radius + int'($urandom_range(2 * noise, 0)) - noise;
        if ($urandom_range(1, 0) == 1) begin
          re_v = -re_v;
        end
        if ($urandom_range(1, 0) == 1) begin
          im_v = -im_v;
        end
      end else if (kind < 8) begin
        re_v = int'($urandom_range(3000, 0)) - 1500;
        im_v = int'($urandom_range(3000, 0)) - 1500;
      end else begin
        re_v = $urandom_range(65535, 0);
        im_v = $urandom_range(65535, 0);
      end
      send_symbol(16'(re_v), 16'(im_v));
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (done_count != sent_count) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] gate, input logic [15:0] weak_err,
                            input logic [15:0] limit);
    cfg_we <= 1'b1;
    cfg_index <= CFG_AMP_GATE_SQ;
    cfg_data <= gate;
    @(posedge clk);
    cfg_index <= CFG_GATED_ERROR;
    cfg_data <= {16'b0, weak_err};
    @(posedge clk);
    cfg_index <= CFG_SYNC_THRESHOLD;
    cfg_data <= {16'b0, limit};
    @(posedge clk);
    cfg_index <= CFG_UNUSED;
    cfg_data <= $urandom;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 20;
    recv_idle_pct = 20;

    send_symbol(-16'sd32768, -16'sd32768);
    send_symbol(16'sd32767, 16'sd32767);
    send_symbol(-16'sd32768, 16'sd32767);
    send_symbol(16'sd32767, -16'sd32768);
    send_symbol(16'sd0, 16'sd0);
    send_symbol(16'sd0, -16'sd1);
    send_symbol(-16'sd1, 16'sd0);
    send_symbol(-16'sd1, -16'sd1);
    send_symbol(16'sd1, 16'sd1);
    send_symbol(16'sd16384, 16'sd0);
    send_symbol(16'sd0, 16'sd16384);
    send_symbol(-16'sd16384, 16'sd0);
    send_symbol(16'sd0, -16'sd16384);
    send_symbol(16'sd100, -16'sd100);
    send_symbol(16'sd11585, 16'sd11585);
    send_symbol(-16'sd11585, 16'sd11585);
    send_symbol(-16'sd11585, -16'sd11585);
    send_symbol(16'sd11585, -16'sd11585);
    send_symbol(16'sd11585, 16'sd11585);
    send_symbol(-16'sd11585, -16'sd11585);
    send_symbol(16'sd11585, -16'sd11585);
    send_random(120, 1500);

    drain();
    set_config(32'd0, 16'd0, 16'hFFFF);
    send_random(100, 3000);

    drain();
    set_config(32'h8000_0000, 16'hFFFF, 16'd0);
    send_symbol(-16'sd32768, -16'sd32768);
    send_symbol(16'sd32767, 16'sd32767);
    send_random(80, 800);

    drain();
    send_idle_pct = 0;
    set_config($urandom_range(200000000, 0), 16'($urandom_range(65535, 0)),
               16'($urandom_range(10000, 2000)));
    send_random(150, 2000);

    drain();
    recv_idle_pct = 0;
    set_config(AMP_GATE_SQ_RESET, GATED_ERROR_RESET, SYNC_THRESHOLD_RESET);
    send_random(150, 1000);

    drain();
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #4800000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
